[design/assert_macros.svh]
// assertion macros shared by the rational arithmetic unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, held off while in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked on the clock after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/rau_pkg.sv]
// package of the rational arithmetic unit: operation codes, widths, sequencer states
package rau_pkg;

   localparam int OperandWidthDefault = 32;
   localparam int NumWidth = 32;
   localparam int DenWidth = 31;
   localparam int ResNumWidth = 64;
   localparam int ResDenWidth = 63;
   localparam int WideWidth = 64;
   localparam int CountWidth = 7;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
      OP_MOD = 4'd4, OP_FRAC = 4'd5, OP_INC = 4'd6, OP_DEC = 4'd7,
      OP_EQ = 4'd8, OP_NE = 4'd9, OP_GT = 4'd10, OP_LT = 4'd11,
      OP_GE = 4'd12, OP_LE = 4'd13, OP_TOINT = 4'd14, OP_NONE = 4'd15
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_SUM, ST_MODQ, ST_MODR, ST_MODF,
      ST_MODSUM, ST_GCD_START, ST_GCD_WAIT, ST_RED_NUM, ST_RED_NUM_WAIT,
      ST_RED_DEN, ST_RED_DEN_WAIT, ST_DIRECT, ST_FRACW, ST_INTW, ST_DONE
   } state_type;

   // handshake between sequencer and shared divider
   typedef struct packed {
      logic start;
      logic [WideWidth-1:0] dividend;
      logic [WideWidth-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [WideWidth-1:0] quotient;
      logic [WideWidth-1:0] remainder;
   } div_rsp_type;

endpackage

[design/rau_divider.sv]
// shared unsigned 64-bit restoring divider, one quotient bit per cycle
module rau_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rau_pkg::div_req_type req,
   output rau_pkg::div_rsp_type rsp
);
   import rau_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [WideWidth-1:0] quot_ff, quot_in;
   logic [WideWidth-1:0] rem_ff, rem_in;
   logic [WideWidth-1:0] dsor_ff, dsor_in;
   logic [WideWidth:0]   trial;
   logic [WideWidth:0]   shifted;

   // one shift and subtract step
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dsor_in  = dsor_ff;
      shifted  = {rem_ff, quot_ff[WideWidth-1]};
      trial    = shifted - {1'b0, dsor_ff};
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quot_in  = req.dividend;
         rem_in   = '0;
         dsor_in  = req.divisor;
      end else if (busy_ff) begin
         if (!trial[WideWidth]) begin
            rem_in = trial[WideWidth-1:0];
            quot_in = {quot_ff[WideWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted[WideWidth-1:0];
            quot_in = {quot_ff[WideWidth-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CountWidth'(WideWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quot_ff;
   assign rsp.remainder = rem_ff;

endmodule

[design/rau_sequencer.sv]
// sequencer: products over a shared multiplier, gcd and reduction on the shared divider
module rau_sequencer #(
   parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [3:0]                         op_code,
   input  logic signed [rau_pkg::NumWidth-1:0] a_num,
   input  logic [rau_pkg::DenWidth-1:0]       a_den,
   input  logic signed [rau_pkg::NumWidth-1:0] b_num,
   input  logic [rau_pkg::DenWidth-1:0]       b_den,
   output logic                               busy,
   output logic                               done,
   output logic signed [rau_pkg::ResNumWidth-1:0] res_num,
   output logic [rau_pkg::ResDenWidth-1:0]    res_den,
   output logic                               cmp_true,
   output logic                               error,
   output rau_pkg::div_req_type               div_req,
   input  rau_pkg::div_rsp_type               div_rsp
);
   import rau_pkg::*;

   localparam int DenUsed = OPERAND_WIDTH - 1;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic signed [WideWidth-1:0] an_ff, an_in, bn_ff, bn_in, ad_ff, ad_in, bd_ff, bd_in;
   logic signed [WideWidth-1:0] p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in;
   logic signed [WideWidth-1:0] n_ff, n_in, d_ff, d_in;
   logic [WideWidth-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic signed [WideWidth-1:0] rn_ff, rn_in;
   logic [WideWidth-1:0] rd_ff, rd_in;
   logic cmp_ff, cmp_in, err_ff, err_in, nneg_ff, nneg_in;
   logic signed [NumWidth-1:0] mul_x, mul_y;
   logic signed [WideWidth-1:0] mul_p;
   logic [WideWidth-1:0] nmag;
   logic signed [WideWidth-1:0] an_ext, bn_ext;
   logic uses_b;

   // operand extension to operand width
   always_comb begin
      an_ext = WideWidth'(signed'(a_num[OPERAND_WIDTH-1:0]));
      bn_ext = WideWidth'(signed'(b_num[OPERAND_WIDTH-1:0]));
   end

   // multiplier operand select; every operand fits in 32 signed bits
   always_comb begin
      mul_x = an_ff[NumWidth-1:0];
      mul_y = bd_ff[NumWidth-1:0];
      priority if (state_ff == ST_MUL1 && op_ff == OP_NONE) begin
         mul_x = p1_ff[NumWidth-1:0];
         mul_y = ad_ff[NumWidth-1:0];
      end else if (state_ff == ST_MUL1 && op_ff == OP_MUL) begin
         mul_y = bn_ff[NumWidth-1:0];
      end else if (state_ff == ST_MUL2) begin
         mul_x = bn_ff[NumWidth-1:0];
         mul_y = ad_ff[NumWidth-1:0];
      end else if (state_ff == ST_MUL3) begin
         mul_x = ad_ff[NumWidth-1:0];
         mul_y = bd_ff[NumWidth-1:0];
      end
   end

   // shared multiplier, operands at most 32 bits wide
   assign mul_p = WideWidth'(mul_x) * WideWidth'(mul_y);
   assign nmag  = n_ff[WideWidth-1] ? WideWidth'(-n_ff) : n_ff;
   assign uses_b = (op_code <= 4'(OP_DIV)) ||
                   (op_code >= 4'(OP_EQ) && op_code <= 4'(OP_LE));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in; an_ff <= an_in; bn_ff <= bn_in; ad_ff <= ad_in; bd_ff <= bd_in;
      p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in; n_ff <= n_in; d_ff <= d_in;
      gx_ff <= gx_in; gy_ff <= gy_in; rn_ff <= rn_in; rd_ff <= rd_in;
      cmp_ff <= cmp_in; err_ff <= err_in; nneg_ff <= nneg_in;
   end

   // next state and datapath control
   always_comb begin
      state_in = state_ff;
      op_in = op_ff; an_in = an_ff; bn_in = bn_ff; ad_in = ad_ff; bd_in = bd_ff;
      p1_in = p1_ff; p2_in = p2_ff; p3_in = p3_ff; n_in = n_ff; d_in = d_ff;
      gx_in = gx_ff; gy_in = gy_ff; rn_in = rn_ff; rd_in = rd_ff;
      cmp_in = cmp_ff; err_in = err_ff; nneg_in = nneg_ff;
      div_req.start = 1'b0;
      div_req.dividend = gx_ff;
      div_req.divisor = gy_ff;
      done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in = op_type'(op_code);
               an_in = an_ext; bn_in = bn_ext;
               ad_in = WideWidth'(a_den[DenUsed-1:0]);
               bd_in = WideWidth'(b_den[DenUsed-1:0]);
               rn_in = '0; rd_in = WideWidth'(1); cmp_in = 1'b0; err_in = 1'b0;
               if (op_code != 4'(OP_NONE) && (a_den[DenUsed-1:0] == '0 ||
                   (uses_b && b_den[DenUsed-1:0] == '0))) begin
                  err_in = 1'b1;
                  state_in = ST_DONE;
               end else if ((op_code == 4'(OP_DIV) || op_code == 4'(OP_MOD))
                            && bn_ext == '0) begin
                  err_in = 1'b1;
                  state_in = ST_DONE;
               end else if (op_code == 4'(OP_NONE)) begin
                  state_in = ST_DONE;
               end else if (op_code == 4'(OP_MOD) || op_code == 4'(OP_FRAC) ||
                            op_code == 4'(OP_TOINT)) begin
                  state_in = ST_MODQ;
               end else if (op_code == 4'(OP_INC) || op_code == 4'(OP_DEC)) begin
                  state_in = ST_DIRECT;
               end else begin
                  state_in = ST_MUL1;
               end
            end
         end
         // lhs, or a_num times b_num for mul
         ST_MUL1: begin
            p1_in = mul_p;
            state_in = ST_MUL2;
         end
         // rhs, or a_den times b_num for div
         ST_MUL2: begin
            p2_in = mul_p;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            p3_in = mul_p;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_GCD_START;
            unique case (op_ff)
               OP_ADD: begin n_in = p1_ff + p2_ff; d_in = p3_ff; end
               OP_SUB: begin n_in = p1_ff - p2_ff; d_in = p3_ff; end
               OP_MUL: begin n_in = p1_ff; d_in = p3_ff; end
               OP_DIV: begin
                  if (bn_ff[WideWidth-1]) begin
                     n_in = -p1_ff; d_in = -p2_ff;
                  end else begin
                     n_in = p1_ff; d_in = p2_ff;
                  end
               end
               default: begin
                  state_in = ST_DONE;
                  unique case (op_ff)
                     OP_EQ: cmp_in = p1_ff == p2_ff;
                     OP_NE: cmp_in = p1_ff != p2_ff;
                     OP_GT: cmp_in = p1_ff > p2_ff;
                     OP_LT: cmp_in = p1_ff < p2_ff;
                     OP_GE: cmp_in = p1_ff >= p2_ff;
                     OP_LE: cmp_in = p1_ff <= p2_ff;
                     default: cmp_in = 1'b0;
                  endcase
               end
            endcase
         end
         // truncated quotient of a by its denominator, signs handled by magnitude
         ST_MODQ: begin
            nneg_in = an_ff[WideWidth-1];
            div_req.start = 1'b1;
            div_req.dividend = an_ff[WideWidth-1] ? WideWidth'(-an_ff) : an_ff;
            div_req.divisor = ad_ff;
            state_in = ST_MODR;
         end
         ST_MODR: begin
            if (div_rsp.done) begin
               p1_in = nneg_ff ? -signed'(div_rsp.quotient) : signed'(div_rsp.quotient);
               p2_in = nneg_ff ? -signed'(div_rsp.remainder) : signed'(div_rsp.remainder);
               unique case (op_ff)
                  OP_FRAC: state_in = ST_FRACW;
                  OP_TOINT: state_in = ST_INTW;
                  default: state_in = ST_MODF;
               endcase
            end
         end
         // integer part modulo b_num
         ST_MODF: begin
            div_req.start = 1'b1;
            div_req.dividend = p1_ff[WideWidth-1] ? WideWidth'(-p1_ff) : p1_ff;
            div_req.divisor = bn_ff[WideWidth-1] ? WideWidth'(-bn_ff) : bn_ff;
            nneg_in = p1_ff[WideWidth-1];
            state_in = ST_MODSUM;
         end
         ST_MODSUM: begin
            if (div_rsp.done) begin
               p1_in = nneg_ff ? -signed'(div_rsp.remainder) : signed'(div_rsp.remainder);
               state_in = ST_MUL1;
               op_in = OP_NONE;
            end
         end
         ST_FRACW: begin rn_in = p2_ff; rd_in = ad_ff; state_in = ST_DONE; end
         ST_INTW: begin rn_in = p1_ff; rd_in = WideWidth'(1); state_in = ST_DONE; end
         ST_DIRECT: begin
            rn_in = (op_ff == OP_INC) ? an_ff + ad_ff : an_ff - ad_ff;
            rd_in = ad_ff;
            state_in = ST_DONE;
         end
         // gcd by Euclid: x holds |n|, y holds d
         ST_GCD_START: begin
            if (n_ff == '0) begin
               rn_in = '0; rd_in = WideWidth'(1);
               state_in = ST_DONE;
            end else begin
               gx_in = nmag; gy_in = d_ff;
               state_in = ST_GCD_WAIT;
               div_req.start = 1'b1;
               div_req.dividend = nmag;
               div_req.divisor = d_ff;
            end
         end
         ST_GCD_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder == '0) begin
                  state_in = ST_RED_NUM;
               end else begin
                  gx_in = gy_ff; gy_in = div_rsp.remainder;
                  div_req.start = 1'b1;
                  div_req.dividend = gy_ff;
                  div_req.divisor = div_rsp.remainder;
               end
            end
         end
         ST_RED_NUM: begin
            div_req.start = 1'b1;
            div_req.dividend = nmag;
            div_req.divisor = gy_ff;
            state_in = ST_RED_NUM_WAIT;
         end
         ST_RED_NUM_WAIT: begin
            if (div_rsp.done) begin
               rn_in = n_ff[WideWidth-1] ? -signed'(div_rsp.quotient)
                                         : signed'(div_rsp.quotient);
               state_in = ST_RED_DEN;
            end
         end
         ST_RED_DEN: begin
            div_req.start = 1'b1;
            div_req.dividend = d_ff;
            div_req.divisor = gy_ff;
            state_in = ST_RED_DEN_WAIT;
         end
         ST_RED_DEN_WAIT: begin
            if (div_rsp.done) begin
               rd_in = div_rsp.quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            done = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // mod rejoins here: numerator ip*ad + fp, op marker OP_NONE
      if (state_ff == ST_MUL1 && op_ff == OP_NONE) begin
         p1_in = mul_p;
         state_in = ST_MUL3;
      end
      if (state_ff == ST_MUL3 && op_ff == OP_NONE) begin
         n_in = p1_ff + p2_ff;
         d_in = ad_ff;
         p3_in = p3_ff;
         state_in = ST_GCD_START;
      end
   end

   assign busy     = state_ff != ST_IDLE;
   assign res_num  = err_ff ? '0 : rn_ff;
   assign res_den  = err_ff ? ResDenWidth'(1) : rd_ff[ResDenWidth-1:0];
   assign cmp_true = cmp_ff & ~err_ff;
   assign error    = err_ff;

endmodule

[design/rational_arithmetic_unit.sv]
// top level of the rational arithmetic unit
// One beat at a time: start is taken while busy is low; the result shows on the rsp_
// ports for one cycle with rsp_valid and cannot be stalled. Add, sub, mul and div pass
// the multiply states MUL1, MUL2 and MUL3, then Euclid's gcd and two reductions on one
// 64-bit shift and subtract divider; mod adds two divider passes, frac and toint take
// one pass without gcd, and inc, dec and compares do not use the divider.
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [3:0]                             req_operation,
   input  logic signed [rau_pkg::NumWidth-1:0]    req_a_num,
   input  logic [rau_pkg::DenWidth-1:0]           req_a_den,
   input  logic signed [rau_pkg::NumWidth-1:0]    req_b_num,
   input  logic [rau_pkg::DenWidth-1:0]           req_b_den,
   output logic                                   rsp_valid,
   output logic signed [rau_pkg::ResNumWidth-1:0] rsp_res_num,
   output logic [rau_pkg::ResDenWidth-1:0]        rsp_res_den,
   output logic                                   rsp_cmp_true,
   output logic                                   rsp_error
);
   import rau_pkg::*;
   `include "assert_macros.svh"

   div_req_type div_req;
   div_rsp_type div_rsp;

   rau_divider u_divider (
      .clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp)
   );

   rau_sequencer #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_sequencer (
      .clock(clock), .reset(reset), .start(start), .op_code(req_operation),
      .a_num(req_a_num), .a_den(req_a_den), .b_num(req_b_num), .b_den(req_b_den),
      .busy(busy), .done(rsp_valid), .res_num(rsp_res_num), .res_den(rsp_res_den),
      .cmp_true(rsp_cmp_true), .error(rsp_error),
      .div_req(div_req), .div_rsp(div_rsp)
   );

   `ASSERT_IMPLIES(a_valid_busy, clock, reset, rsp_valid, busy, "result outside busy")
   `ASSERT_NEXT(a_valid_one, clock, reset, rsp_valid, !rsp_valid, "result held twice")
   `ASSERT_IMPLIES(a_err_clean, clock, reset, rsp_valid && rsp_error,
      rsp_res_num == '0 && rsp_res_den == 1 && !rsp_cmp_true, "error answer not clean")
   `ASSERT_NEXT(a_take_busy, clock, reset, start && !busy, busy, "accepted beat not busy")

endmodule

[verif/rational_arithmetic_unit_test.sv]
// testbench of the rational arithmetic unit: directed table, then random fractions checked against a predictor
module rational_arithmetic_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rau_pkg::*;

   localparam int StallLimit = 40000;
   localparam int TailCycles = 200;
   localparam int RandomItems = 1880;

   typedef struct {
      longint          num;
      logic [62:0]     den;
      bit              cmp;
      bit              err;
   } fraction_result_type;

   typedef struct {
      op_type              op;
      logic signed [31:0]  an;
      logic [30:0]         ad;
      logic signed [31:0]  bn;
      logic [30:0]         bd;
      bit                  typed;
      fraction_result_type res;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [3:0]          req_operation;
   logic signed [31:0]  req_a_num;
   logic [30:0]         req_a_den;
   logic signed [31:0]  req_b_num;
   logic [30:0]         req_b_den;
   logic                rsp_valid;
   logic signed [63:0]  rsp_res_num;
   logic [62:0]         rsp_res_den;
   logic                rsp_cmp_true;
   logic                rsp_error;

   fraction_result_type pending_results[$];
   stim_row_type        directed_rows[$];
   int                  fail_count = 0;
   int                  quiet_cycles = 0;
   int                  idle_pct = 0;

   rational_arithmetic_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_a_num(req_a_num), .req_a_den(req_a_den),
      .req_b_num(req_b_num), .req_b_den(req_b_den), .rsp_valid(rsp_valid),
      .rsp_res_num(rsp_res_num), .rsp_res_den(rsp_res_den),
      .rsp_cmp_true(rsp_cmp_true), .rsp_error(rsp_error)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // divide out the gcd, zero numerator goes to 0/1
   function automatic void reduce_fraction(input longint n, input longint d,
                                           output longint rn, output longint rd);
      longint unsigned g;
      longint unsigned n_mag;
      n_mag = (n < 0) ? longint'(-n) : longint'(n);
      if (n == 0) begin
         rn = 0;
         rd = 1;
      end else begin
         g = euclid_gcd(n_mag, longint'(d));
         rn = n / longint'(g);
         rd = d / longint'(g);
      end
   endfunction

   function automatic fraction_result_type predict_fraction(op_type op,
                                                            logic signed [31:0] a_num,
                                                            logic [30:0] a_den,
                                                            logic signed [31:0] b_num,
                                                            logic [30:0] b_den);
      fraction_result_type r;
      longint an, ad, bn, bd, lhs, rhs, rn, rd, ip, fp;
      bit uses_b;
      an = longint'(a_num);
      ad = longint'(a_den);
      bn = longint'(b_num);
      bd = longint'(b_den);
      lhs = an * bd;
      rhs = bn * ad;
      rn = 0;
      rd = 1;
      r.cmp = 0;
      r.err = 0;
      uses_b = (op <= OP_DIV) || (op >= OP_EQ && op <= OP_LE);
      if (op != OP_NONE && (ad == 0 || (uses_b && bd == 0))) begin
         r.err = 1;
      end else begin
         case (op)
            OP_ADD: reduce_fraction(lhs + rhs, ad * bd, rn, rd);
            OP_SUB: reduce_fraction(lhs - rhs, ad * bd, rn, rd);
            OP_MUL: reduce_fraction(an * bn, ad * bd, rn, rd);
            OP_DIV: begin
               if (bn == 0) r.err = 1;
               else if (bn < 0) reduce_fraction(-lhs, -(ad * bn), rn, rd);
               else reduce_fraction(lhs, ad * bn, rn, rd);
            end
            OP_MOD: begin
               if (bn == 0) begin
                  r.err = 1;
               end else begin
                  ip = (an / ad) % bn;
                  fp = an % ad;
                  reduce_fraction(ip * ad + fp, ad, rn, rd);
               end
            end
            OP_FRAC: begin rn = an % ad; rd = ad; end
            OP_INC: begin rn = an + ad; rd = ad; end
            OP_DEC: begin rn = an - ad; rd = ad; end
            OP_EQ: r.cmp = (lhs == rhs);
            OP_NE: r.cmp = (lhs != rhs);
            OP_GT: r.cmp = (lhs > rhs);
            OP_LT: r.cmp = (lhs < rhs);
            OP_GE: r.cmp = (lhs >= rhs);
            OP_LE: r.cmp = (lhs <= rhs);
            OP_TOINT: begin rn = an / ad; rd = 1; end
            default: ;
         endcase
      end
      if (r.err) begin
         rn = 0;
         rd = 1;
         r.cmp = 0;
      end
      r.num = rn;
      r.den = rd[62:0];
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic void add_row(op_type op, logic signed [31:0] an, logic [30:0] ad,
                                   logic signed [31:0] bn, logic [30:0] bd, bit typed,
                                   longint en, longint ed, bit ec, bit ee);
      stim_row_type row;
      row.op = op; row.an = an; row.ad = ad; row.bn = bn; row.bd = bd;
      row.typed = typed;
      row.res.num = en; row.res.den = ed[62:0]; row.res.cmp = ec; row.res.err = ee;
      directed_rows = {directed_rows, row};
   endfunction

   // present one beat and hold it until taken, with random sender gaps
   task automatic send_beat(op_type op, logic signed [31:0] an, logic [30:0] ad,
                            logic signed [31:0] bn, logic [30:0] bd,
                            bit typed, fraction_result_type typed_res);
      bit taken;
      fraction_result_type expected;
      forever begin
         @(negedge clock);
         if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
         end else begin
            break;
         end
      end
      start <= 1'b1;
      req_operation <= op;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      taken = 0;
      while (!taken) begin
         @(posedge clock);
         if (!busy) begin
            taken = 1;
            expected = typed ? typed_res : predict_fraction(op, an, ad, bn, bd);
            pending_results = {pending_results, expected};
         end
      end
   endtask

   // random operand, small magnitudes most of the time to keep gcd chains short
   function automatic logic signed [31:0] rand_num();
      int k;
      if ($urandom_range(99) < 60) begin
         k = $urandom_range(1, 16);
         return $signed($urandom_range(0, (1 << k) - 1)) - (1 <<< (k - 1));
      end
      return $signed($urandom);
   endfunction

   function automatic logic [30:0] rand_den();
      int k;
      if ($urandom_range(99) < 2) return '0;
      if ($urandom_range(99) < 60) begin
         k = $urandom_range(1, 16);
         return 31'($urandom_range(1, (1 << k) - 1));
      end
      return 31'($urandom_range(1, 32'h7FFF_FFFF));
   endfunction

   // result checking
   always @(posedge clock) begin
      fraction_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            e = pending_results.pop_front();
            if (rsp_res_num !== e.num)
               report_mismatch($sformatf("res_num %0d, expected %0d", rsp_res_num, e.num));
            if (rsp_res_den !== e.den)
               report_mismatch($sformatf("res_den %0d, expected %0d", rsp_res_den, e.den));
            if (rsp_cmp_true !== e.cmp)
               report_mismatch($sformatf("cmp_true %0b, expected %0b", rsp_cmp_true, e.cmp));
            if (rsp_error !== e.err)
               report_mismatch($sformatf("error %0b, expected %0b", rsp_error, e.err));
         end
      end
   end

   // watchdog on cycles with no traffic
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      op_type op;
      fraction_result_type none;
      none = '{num: 0, den: 1, cmp: 0, err: 0};
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_NONE;
      req_a_num = '0;
      req_a_den = 31'd1;
      req_b_num = '0;
      req_b_den = 31'd1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every operation, extremes, error answers
      add_row(OP_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3, 1, 5, 6, 0, 0);
      add_row(OP_ADD, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF,
              0, 0, 0, 0, 0);
      add_row(OP_SUB, 32'sd3, 31'd4, 32'sd3, 31'd4, 1, 0, 1, 0, 0);
      add_row(OP_SUB, 32'sh7FFF_FFFF, 31'd1, 32'sh8000_0000, 31'd1, 1,
              64'sd4294967295, 1, 0, 0);
      add_row(OP_MUL, 32'sh8000_0000, 31'd1, 32'sh8000_0000, 31'd1, 1,
              64'sd4611686018427387904, 1, 0, 0);
      add_row(OP_MUL, 32'sd0, 31'd5, 32'sd7, 31'd9, 1, 0, 1, 0, 0);
      add_row(OP_DIV, 32'sd1, 31'd2, 32'sd0, 31'd3, 1, 0, 1, 0, 1);
      add_row(OP_DIV, 32'sd3, 31'd4, -32'sd9, 31'd2, 0, 0, 0, 0, 0);
      add_row(OP_DIV, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000, 31'd1, 0, 0, 0, 0, 0);
      add_row(OP_MOD, 32'sd1, 31'd2, 32'sd0, 31'd1, 1, 0, 1, 0, 1);
      add_row(OP_MOD, -32'sd17, 31'd3, 32'sd2, 31'd0, 0, 0, 0, 0, 0);
      add_row(OP_MOD, 32'sh8000_0000, 31'd1, -32'sd1, 31'd1, 1, 0, 1, 0, 0);
      add_row(OP_FRAC, -32'sd7, 31'd2, 32'sd0, 31'd0, 1, -1, 2, 0, 0);
      add_row(OP_INC, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sd0, 31'd1, 0, 0, 0, 0, 0);
      add_row(OP_DEC, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sd0, 31'd1, 0, 0, 0, 0, 0);
      add_row(OP_EQ, 32'sd1, 31'd2, 32'sd2, 31'd4, 1, 0, 1, 1, 0);
      add_row(OP_NE, 32'sd1, 31'd2, 32'sd2, 31'd4, 1, 0, 1, 0, 0);
      add_row(OP_GT, 32'sd1, 31'd2, 32'sd1, 31'd3, 1, 0, 1, 1, 0);
      add_row(OP_LT, -32'sd1, 31'd2, 32'sd1, 31'd3, 1, 0, 1, 1, 0);
      add_row(OP_GE, 32'sd1, 31'd3, 32'sd1, 31'd2, 1, 0, 1, 0, 0);
      add_row(OP_LE, 32'sd1, 31'd3, 32'sd1, 31'd3, 1, 0, 1, 1, 0);
      add_row(OP_TOINT, -32'sd7, 31'd2, 32'sd0, 31'd1, 1, -3, 1, 0, 0);
      add_row(OP_ADD, 32'sd1, 31'd0, 32'sd1, 31'd2, 1, 0, 1, 0, 1);
      add_row(OP_LT, 32'sd1, 31'd2, 32'sd1, 31'd0, 1, 0, 1, 0, 1);
      add_row(OP_NONE, 32'sd5, 31'd0, 32'sd3, 31'd0, 1, 0, 1, 0, 0);
      foreach (directed_rows[i])
         send_beat(directed_rows[i].op, directed_rows[i].an, directed_rows[i].ad,
                   directed_rows[i].bn, directed_rows[i].bd, directed_rows[i].typed,
                   directed_rows[i].res);

      // random part in four sender phases
      for (int n = 0; n < RandomItems; n++) begin
         case ((n * 4) / RandomItems)
            0: idle_pct = 0;
            1: idle_pct = 70;
            2: idle_pct = 0;
            default: idle_pct = 32;
         endcase
         op = ($urandom_range(99) < 2) ? OP_NONE : op_type'($urandom_range(0, 14));
         send_beat(op, rand_num(), rand_den(),
                   ($urandom_range(99) < 4) ? 32'sd0 : rand_num(), rand_den(), 0, none);
      end
      @(negedge clock);
      start <= 1'b0;

      // drain
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
